>>> rtl/core/ic3_pkg.sv
// Shared constants, codes and types of the 3x3 image convolution filter.
package ic3_pkg;

  // Field and register widths.
  localparam int PixW   = 8;
  localparam int CoordW = 10;
  localparam int DimW   = 11;
  localparam int ModeW  = 2;
  localparam int IdxW   = 2;

  // Largest row length held by the line memory, and largest image height.
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int RamAw     = $clog2(MaxWidth);
  localparam int MinDim    = 3;

  // Reset values of the configuration registers.
  localparam logic [DimW-1:0] DimReset = DimW'(256);

  // Kernel modes. Code 3 behaves as the Laplacian.
  localparam logic [ModeW-1:0] ModeBox   = 2'd0;
  localparam logic [ModeW-1:0] ModeGauss = 2'd1;
  localparam logic [ModeW-1:0] ModeLap   = 2'd2;

  // Configuration register indexes.
  localparam logic [IdxW-1:0] RegMode   = 2'd0;
  localparam logic [IdxW-1:0] RegWidth  = 2'd1;
  localparam logic [IdxW-1:0] RegHeight = 2'd2;

  // Reciprocal of nine in 0.16 fixed point; exact floor for sums up to 2295.
  localparam int BoxSumW = 12;
  localparam int RecipW  = 13;
  localparam logic [RecipW-1:0] Recip9 = 13'd7282;

  // 3x3 neighborhood: [row][col], row 0 oldest line, col 0 oldest column.
  typedef logic [2:0][2:0][PixW-1:0] ic3_win_t;

  // Per-pixel bookkeeping carried down the pipeline.
  typedef struct packed {
    logic              emit;
    logic              last;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
  } ic3_meta_t;

endpackage

>>> rtl/core/ic3_pix_if.sv
// Pixel input channel: valid/ready handshake with one grayscale pixel.
interface ic3_pix_if
  import ic3_pkg::*;
();

  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

>>> rtl/core/ic3_res_if.sv
// Result output channel: valid/ready handshake with one filtered pixel.
interface ic3_res_if
  import ic3_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [PixW-1:0]   value;
  logic [CoordW-1:0] out_row;
  logic [CoordW-1:0] out_col;
  logic              last;

  modport source (output valid, output value, output out_row, output out_col,
                  output last, input ready);
  modport sink (input valid, input value, input out_row, input out_col,
                input last, output ready);
endinterface

>>> rtl/core/image_conv3x3_filter_top.sv
// Top level of the streaming 3x3 image convolution filter.
//
// Pixels enter in raster order, one per transfer, and the block accepts one
// pixel in every clock cycle while results are taken. For every pixel at row
// r >= 2 and column c >= 2 one result leaves via the stage 1, stage 2 and
// output registers, filtered over the 3x3 neighborhood around (r-1, c-1); border
// pixels give no result and the last interior pixel of an image carries last.
// The rate is set by the line memory, which is read once and written once per
// pixel through separate ports. The line memory needs no clearing after reset.
// Any register write restarts the image at row 0, column 0; write registers
// only while no pixel is in flight.
module image_conv3x3_filter_top
  import ic3_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_idx_i,
  input  logic [DimW-1:0] cfg_data_i,
  ic3_pix_if.sink         pix_in,
  ic3_res_if.source       res_out
);

  // Configuration registers.
  logic [ModeW-1:0] mode_q;
  logic [DimW-1:0]  width_q;
  logic [DimW-1:0]  height_q;
  logic             cfg_hit;

  // Position counters.
  logic [CoordW-1:0] col_q, col_d;
  logic [CoordW-1:0] row_q, row_d;
  logic [DimW-1:0]   width_eff;
  logic [DimW-1:0]   height_eff;
  logic              col_end;
  logic              row_end;
  ic3_meta_t         in_meta;

  // Pipeline stage registers.
  logic              s1_v_q;
  logic [PixW-1:0]   s1_px_q;
  logic [CoordW-1:0] s1_col_q;
  ic3_meta_t         s1_meta_q;
  logic              s2_v_q;
  ic3_meta_t         s2_meta_q;
  ic3_win_t          win_q, win_d;
  logic              out_v_q;
  logic [PixW-1:0]   out_value_q;
  ic3_meta_t         out_meta_q;

  // Handshake and memory signals.
  logic              in_xfer;
  logic              s1_adv;
  logic              s2_adv;
  logic              s1_ready;
  logic              s2_ready;
  logic              out_ready;
  logic [2*PixW-1:0] ram_rdata;
  logic [PixW-1:0]   line_top;
  logic [PixW-1:0]   line_mid;
  logic [PixW-1:0]   kern_value;

  // Configuration writes; any known index restarts the image.
  assign cfg_hit = cfg_we_i &&
                   (cfg_idx_i == RegMode || cfg_idx_i == RegWidth ||
                    cfg_idx_i == RegHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeBox;
      width_q  <= DimReset;
      height_q <= DimReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMode:   mode_q   <= cfg_data_i[ModeW-1:0];
        RegWidth:  width_q  <= cfg_data_i;
        RegHeight: height_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Effective image size, held to the supported range.
  always_comb begin
    if (width_q < DimW'(MinDim)) begin
      width_eff = DimW'(MinDim);
    end else if (width_q > DimW'(MaxWidth)) begin
      width_eff = DimW'(MaxWidth);
    end else begin
      width_eff = width_q;
    end
    if (height_q < DimW'(MinDim)) begin
      height_eff = DimW'(MinDim);
    end else if (height_q > DimW'(MaxHeight)) begin
      height_eff = DimW'(MaxHeight);
    end else begin
      height_eff = height_q;
    end
  end

  // Ready chain: each stage moves when the one after it frees up.
  assign out_ready    = !out_v_q || res_out.ready;
  assign s2_ready     = !s2_v_q || out_ready;
  assign s1_ready     = !s1_v_q || s2_ready;
  assign pix_in.ready = s1_ready;
  assign in_xfer      = pix_in.valid && s1_ready;
  assign s1_adv       = s1_v_q && s2_ready;
  assign s2_adv       = s2_v_q && out_ready;

  // Position of the incoming pixel and the result it will produce.
  assign col_end = ({1'b0, col_q} == width_eff - DimW'(1));
  assign row_end = ({1'b0, row_q} == height_eff - DimW'(1));

  always_comb begin
    in_meta.emit = (row_q >= CoordW'(2)) && (col_q >= CoordW'(2));
    in_meta.last = row_end && col_end;
    in_meta.row  = row_q - CoordW'(1);
    in_meta.col  = col_q - CoordW'(1);
    col_d        = col_q;
    row_d        = row_q;
    if (in_xfer) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + CoordW'(1);
      end else begin
        col_d = col_q + CoordW'(1);
      end
    end
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1: pixel waits here for the line memory read of its column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_xfer) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_px_q   <= pix_in.pixel;
      s1_col_q  <= col_q;
      s1_meta_q <= in_meta;
    end
  end

  // Line memory: read the column on transfer, shift it up one row afterwards.
  ic3_line_ram u_line_ram (
    .clk_i   (clk_i),
    .re_i    (in_xfer),
    .raddr_i (RamAw'(col_q)),
    .rdata_o (ram_rdata),
    .we_i    (s1_adv),
    .waddr_i (RamAw'(s1_col_q)),
    .wdata_i ({line_mid, s1_px_q})
  );

  assign line_top = ram_rdata[PixW +: PixW];
  assign line_mid = ram_rdata[0 +: PixW];

  // Window shift: columns move left, the new column enters on the right.
  always_comb begin
    win_d = win_q;
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = line_top;
    win_d[1][2] = line_mid;
    win_d[2][2] = s1_px_q;
  end

  // Stage 2: the window and the bookkeeping of the pending result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      s2_v_q <= 1'b0;
    end else if (s1_adv) begin
      win_q  <= win_d;
      s2_v_q <= s1_meta_q.emit;
    end else if (s2_adv) begin
      s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_meta_q <= s1_meta_q;
    end
  end

  // Filter arithmetic on the current window.
  ic3_kernel u_kernel (
    .mode_i  (mode_q),
    .win_i   (win_q),
    .value_o (kern_value)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s2_adv) begin
      out_v_q <= 1'b1;
    end else if (res_out.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_value_q <= kern_value;
      out_meta_q  <= s2_meta_q;
    end
  end

  assign res_out.valid   = out_v_q;
  assign res_out.value   = out_value_q;
  assign res_out.out_row = out_meta_q.row;
  assign res_out.out_col = out_meta_q.col;
  assign res_out.last    = out_meta_q.last;

  // The memory never reads and writes the same column in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s1_adv) |-> (col_q != s1_col_q))
    else $error("line memory read and write collide on one column");

  // The window only moves when a pixel leaves stage 1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(win_q))
    else $error("window changed without a stage 1 transfer");

  // The last result sits at the bottom-right interior pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_out.valid && res_out.last) |->
      ({1'b0, res_out.out_col} == width_eff - DimW'(2) &&
       {1'b0, res_out.out_row} == height_eff - DimW'(2)))
    else $error("last flag on a pixel that is not the final interior one");

  // Every result is an interior pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid |-> (res_out.out_row != '0 && res_out.out_col != '0))
    else $error("result emitted for a border pixel");

endmodule

>>> rtl/core/ic3_line_ram.sv
// Two-line pixel memory: one entry per column holds the two previous rows.
module ic3_line_ram
  import ic3_pkg::*;
(
  input  logic                clk_i,
  input  logic                re_i,
  input  logic [RamAw-1:0]    raddr_i,
  output logic [2*PixW-1:0]   rdata_o,
  input  logic                we_i,
  input  logic [RamAw-1:0]    waddr_i,
  input  logic [2*PixW-1:0]   wdata_i
);

  // Upper byte is the older row, lower byte the newer row.
  logic [2*PixW-1:0] mem [MaxWidth];
  logic [2*PixW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ic3_kernel.sv
// Kernel arithmetic: box average, 1-2-1 Gaussian and Laplacian on a 3x3 window.
module ic3_kernel
  import ic3_pkg::*;
(
  input  logic [ModeW-1:0] mode_i,
  input  ic3_win_t         win_i,
  output logic [PixW-1:0]  value_o
);

  logic [BoxSumW-1:0]        box_sum;
  logic [BoxSumW-1:0]        gauss_sum;
  logic [DimW-1:0]           nbr_sum;
  logic [BoxSumW+RecipW-1:0] box_prod;
  logic [PixW-1:0]           lap_val;

  // Plain and weighted sums over the window.
  always_comb begin
    box_sum   = '0;
    gauss_sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        box_sum = box_sum + BoxSumW'(win_i[i][j]);
        if (i == 1 && j == 1) begin
          gauss_sum = gauss_sum + (BoxSumW'(win_i[i][j]) << 2);
        end else if (i == 1 || j == 1) begin
          gauss_sum = gauss_sum + (BoxSumW'(win_i[i][j]) << 1);
        end else begin
          gauss_sum = gauss_sum + BoxSumW'(win_i[i][j]);
        end
      end
    end
  end

  // Divide by nine through the fixed-point reciprocal.
  assign box_prod = {{RecipW{1'b0}}, box_sum} * {{BoxSumW{1'b0}}, Recip9};

  // Laplacian keeps only the low byte, so the neighbor sum needs its low byte only.
  assign nbr_sum = box_sum[DimW-1:0] - DimW'(win_i[1][1]);
  assign lap_val = nbr_sum[PixW-1:0] - {win_i[1][1][PixW-4:0], 3'b000};

  // Mode select.
  always_comb begin
    case (mode_i)
      ModeBox:   value_o = box_prod[16 +: PixW];
      ModeGauss: value_o = gauss_sum[4 +: PixW];
      default:   value_o = lap_val;
    endcase
  end

endmodule
